// ===== rtl/sc1a_pkg.sv =====
// Shared types, scancode constants and the set 1 key tables for the
// scancode-to-ASCII unit. No dependencies.
package sc1a_pkg;

	localparam logic [7:0] CODE_PREFIX_EXT   = 8'hE0;
	localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] CODE_EXT_SLASH    = 8'h35;
	localparam logic [7:0] CODE_ESC          = 8'h01;
	localparam logic [7:0] CODE_F1           = 8'h3B;
	localparam logic [7:0] CODE_F2           = 8'h3C;
	localparam logic [6:0] CHAR_SLASH        = 7'h2F;
	localparam logic [6:0] CHAR_NONE         = 7'h00;

	typedef logic [7:0] scan_code_t;
	typedef logic [6:0] ascii_char_t;

	typedef struct packed {
		logic shift_held;
		logic extended_pending;
	} flags_t;

	typedef struct packed {
		logic        hit;
		ascii_char_t ch;
	} result_t;

	// unshifted table, make codes 0x00..0x4E; everything else is empty
	function automatic ascii_char_t plain_lut(input logic [6:0] idx);
		ascii_char_t c;
		case (idx)
			7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;  7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;  7'd9:  c = 7'h38;
			7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;  7'd13: c = 7'h3D;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h71;  7'd17: c = 7'h77;
			7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;  7'd21: c = 7'h79;
			7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;  7'd25: c = 7'h70;
			7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;  7'd30: c = 7'h61;
			7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;  7'd34: c = 7'h67;
			7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;  7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;  7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;  7'd47: c = 7'h76;
			7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;  7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;  7'd53: c = 7'h2F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			7'd74: c = 7'h2D;  7'd78: c = 7'h2B;
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

	// shifted table
	function automatic ascii_char_t upper_lut(input logic [6:0] idx);
		ascii_char_t c;
		case (idx)
			7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;  7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;  7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;  7'd13: c = 7'h2B;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h51;  7'd17: c = 7'h57;
			7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;  7'd21: c = 7'h59;
			7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4F;  7'd25: c = 7'h50;
			7'd26: c = 7'h7B;  7'd27: c = 7'h7D;  7'd28: c = 7'h0A;  7'd30: c = 7'h41;
			7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;  7'd34: c = 7'h47;
			7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;  7'd38: c = 7'h4C;
			7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;  7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;  7'd47: c = 7'h56;
			7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;  7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;  7'd53: c = 7'h3F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			7'd74: c = 7'h2D;  7'd78: c = 7'h2B;
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/sc1a_if.sv =====
// Valid/ready channel interfaces for scancodes in and characters out.
// Depends on sc1a_pkg.
interface sc1a_code_if;
	import sc1a_pkg::*;
	logic       valid;
	logic       ready;
	scan_code_t scan_code;
	modport source (output valid, output scan_code, input ready);
	modport sink (input valid, input scan_code, output ready);
endinterface

interface sc1a_char_if;
	import sc1a_pkg::*;
	logic        valid;
	logic        ready;
	ascii_char_t ascii_char;
	modport source (output valid, output ascii_char, input ready);
	modport sink (input valid, input ascii_char, output ready);
endinterface

// ===== rtl/scancode_set1_to_ascii_unit.sv =====
// Set 1 scancode to ASCII translator: input register, table lookup, result register.
// A character passes from the input register to the result register after its scancode transfer.
// Throughput: one scancode per cycle; the input stage only stalls when a result
// is waiting in the output register and the sink is not ready.
// Reset (arst_n low): shift and extended flags clear, special mode off, both stages empty.
// Depends on sc1a_pkg, sc1a_if, sc1a_translate.
module scancode_set1_to_ascii_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	sc1a_code_if.sink          codes,
	sc1a_char_if.source        chars
);
	import sc1a_pkg::*;

	logic        valid_s1;
	scan_code_t  code_s1;
	flags_t      flags_q;
	flags_t      flags_nxt;
	logic        special_mode_q;
	logic        out_valid_q;
	ascii_char_t out_char_q;
	result_t     res;
	logic        advance;

	sc1a_translate u_translate (
		.code         (code_s1),
		.flags        (flags_q),
		.special_mode (special_mode_q),
		.flags_nxt    (flags_nxt),
		.res          (res)
	);

	// an item with no character never waits on the output register
	assign advance     = valid_s1 && (!res.hit || !out_valid_q || chars.ready);
	assign codes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			flags_q        <= '0;
			special_mode_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				special_mode_q <= cfg_wr_data;
			end
			if (codes.valid && codes.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				flags_q <= flags_nxt;
			end
			if (advance && res.hit) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (codes.valid && codes.ready) begin
			code_s1 <= codes.scan_code;
		end
		if (advance && res.hit) begin
			out_char_q <= res.ch;
		end
	end

	assign chars.valid      = out_valid_q;
	assign chars.ascii_char = out_char_q;

endmodule

// ===== rtl/sc1a_translate.sv =====
// Combinational translation of one scancode: result character and next flags.
// Depends on sc1a_pkg.
module sc1a_translate (
	input  sc1a_pkg::scan_code_t code,
	input  sc1a_pkg::flags_t     flags,
	input  logic                 special_mode,
	output sc1a_pkg::flags_t     flags_nxt,
	output sc1a_pkg::result_t    res
);
	import sc1a_pkg::*;

	ascii_char_t lut_ch;
	logic        raw_key;

	assign lut_ch  = flags.shift_held ? upper_lut(code[6:0]) : plain_lut(code[6:0]);
	assign raw_key = special_mode &&
		(code == CODE_ESC || code == CODE_F1 || code == CODE_F2);

	always_comb begin
		flags_nxt = flags;
		res.ch    = CHAR_NONE;
		if (code == CODE_PREFIX_EXT) begin
			flags_nxt.extended_pending = 1'b1;
		end else if (flags.extended_pending) begin
			flags_nxt.extended_pending = 1'b0;
			if (code == CODE_EXT_SLASH) begin
				res.ch = CHAR_SLASH;
			end
		end else if (code == CODE_LSHIFT_MAKE || code == CODE_RSHIFT_MAKE) begin
			flags_nxt.shift_held = 1'b1;
		end else if (code == CODE_LSHIFT_BREAK || code == CODE_RSHIFT_BREAK) begin
			flags_nxt.shift_held = 1'b0;
		end else if (!code[7]) begin
			res.ch = raw_key ? code[6:0] : lut_ch;
		end
		res.hit = (res.ch != CHAR_NONE);
	end

endmodule

// ===== rtl/sc1a_checker.sv =====
// Port-level checks for scancode_set1_to_ascii_unit, attached by bind.
// Depends on sc1a_pkg.
module sc1a_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input sc1a_pkg::scan_code_t    scan_code,
	input logic                    out_valid,
	input logic                    out_ready,
	input sc1a_pkg::ascii_char_t   ascii_char
);
	import sc1a_pkg::*;

	// a result waiting on the sink holds its character
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char))
		else $error("result dropped or changed while stalled");

	// an empty lookup never becomes a transfer
	a_no_null: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ascii_char != CHAR_NONE)
		else $error("null character presented");

	// a fresh result needs a matching scancode transfer, taken through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching scancode");

	// the extended prefix itself yields no character
	a_prefix_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && scan_code == CODE_PREFIX_EXT |=> ##1 !$rose(out_valid))
		else $error("prefix byte produced a character");

endmodule

bind scancode_set1_to_ascii_unit sc1a_checker u_sc1a_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (codes.valid),
	.in_ready   (codes.ready),
	.scan_code  (codes.scan_code),
	.out_valid  (chars.valid),
	.out_ready  (chars.ready),
	.ascii_char (chars.ascii_char)
);
